// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   localparam int CMD_W  = 3;
   localparam int WORD_W = 32;
   localparam int POS_W  = 5;
   localparam int OCC_W  = 5;
   localparam int ERR_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5,
      CMD_READ_AT    = 3'd6,
      CMD_COUNT      = 3'd7
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic take;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic busy;
      logic rsp_full;
   } ctrl_status_type;

endpackage

// File: rtl/core/deq_req_if.sv
`timescale 1ns / 1ps

interface deq_req_if
   import deq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [WORD_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, command, value, position, input ready);
   modport sink   (input valid, command, value, position, output ready);
endinterface

// File: rtl/core/deq_rsp_if.sv
`timescale 1ns / 1ps

interface deq_rsp_if
   import deq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] data;
   logic [OCC_W-1:0]         occupancy;
   logic [ERR_W-1:0]         error;

   modport source (output valid, data, occupancy, error, input ready);
   modport sink   (input valid, data, occupancy, error, output ready);
endinterface

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl
   import deq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ctrl_cmd_type    ctl_cmd,
   output ctrl_status_type ctl_status
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl_cmd      = '0;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctl_cmd.take = req_valid;
         end
         ST_HOLD: begin
            ctl_cmd.load = out_free;
            if (out_free) begin
               out_valid_in = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign ctl_status.busy     = (state_ff == ST_HOLD);
   assign ctl_status.rsp_full = out_valid_ff;

endmodule

// File: rtl/core/deq_datapath.sv
`timescale 1ns / 1ps

module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             ctl_cmd,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic [OCC_W-1:0]         rsp_occupancy,
   output logic [ERR_W-1:0]         rsp_error
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [DATA_WIDTH-1:0] store [DEPTH];

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  pend_has_ff;
   err_type               pend_err_ff;
   logic [OCC_W-1:0]      pend_occ_ff;
   logic signed [WORD_W-1:0] data_ff;
   logic [OCC_W-1:0]      occ_ff;
   logic [ERR_W-1:0]      err_ff;

   cmd_type               cmd;
   err_type               err;
   logic                  wr_en, rd_en, has_data;
   logic [PTR_W-1:0]      wr_addr, rd_addr;
   logic                  empty, full;
   logic [PTR_W-1:0]      head_dec, head_inc;
   logic [PTR_W-1:0]      back_off, pos_off;
   logic [POS_W-1:0]      pos_m1;
   logic [PTR_W+POS_W-1:0] pos_wide;
   logic [CNT_W+OCC_W-1:0] occ_wide;
   logic [DATA_WIDTH+WORD_W-1:0] val_ext;
   logic [DATA_WIDTH+WORD_W-1:0] rd_ext;

   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign cmd      = cmd_type'(req_command);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - PTR_W'(1);
   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
   assign back_off = count_ff[PTR_W-1:0] - PTR_W'(1);
   assign pos_m1   = req_position - POS_W'(1);
   assign pos_wide = (PTR_W + POS_W)'(pos_m1);
   assign pos_off  = pos_wide[PTR_W-1:0];
   assign val_ext  = {{DATA_WIDTH{1'b0}}, req_value};

   always_comb begin
      err      = ERR_OK;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      has_data = 1'b0;
      wr_addr  = head_ff;
      rd_addr  = head_ff;
      head_in  = head_ff;
      count_in = count_ff;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = slot_of(head_ff, count_ff[PTR_W-1:0]);
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT, CMD_PEEK_FRONT: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               rd_en    = 1'b1;
               has_data = 1'b1;
               rd_addr  = head_ff;
               if (cmd == CMD_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         CMD_POP_BACK, CMD_PEEK_BACK: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               rd_en    = 1'b1;
               has_data = 1'b1;
               rd_addr  = slot_of(head_ff, back_off);
               if (cmd == CMD_POP_BACK) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         CMD_READ_AT: begin
            if (req_position == '0 || CMP_W'(req_position) > CMP_W'(count_ff)) begin
               err = ERR_RANGE;
            end else begin
               rd_en    = 1'b1;
               has_data = 1'b1;
               rd_addr  = slot_of(head_ff, pos_off);
            end
         end
         default: begin
            err = ERR_OK;
         end
      endcase
   end

   assign occ_wide = (CNT_W + OCC_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctl_cmd.take) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.take && wr_en) begin
         store[wr_addr] <= val_ext[DATA_WIDTH-1:0];
      end
      if (ctl_cmd.take && rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.take) begin
         pend_has_ff <= has_data;
         pend_err_ff <= err;
         pend_occ_ff <= occ_wide[OCC_W-1:0];
      end
   end

   assign rd_ext = {{WORD_W{rd_data_ff[DATA_WIDTH-1]}}, rd_data_ff};

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         data_ff <= pend_has_ff ? signed'(rd_ext[WORD_W-1:0]) : '0;
         occ_ff  <= pend_occ_ff;
         err_ff  <= pend_err_ff;
      end
   end

   assign rsp_data      = data_ff;
   assign rsp_occupancy = occ_ff;
   assign rsp_error     = err_ff;

endmodule

// File: rtl/core/double_ended_queue.sv
// Bounded double-ended queue held in a ring store with a head pointer and a count.
// A result beat passes the ring store read and pending stage, then the output register, loaded when free.
// A new command is taken only after the previous one leaves the pending stage for the output register.
// A command may be accepted while the previous result still waits to be taken.
// Synchronous reset empties the queue; the ring store itself is not cleared.
`timescale 1ns / 1ps

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W+OCC_W-1:0] FULL_WIDE = (CNT_W + OCC_W)'(DEPTH);
   localparam logic [OCC_W-1:0] FULL_OCC = FULL_WIDE[OCC_W-1:0];

   ctrl_cmd_type    ctl_cmd;
   ctrl_status_type ctl_status;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .ctl_cmd    (ctl_cmd),
      .ctl_status (ctl_status)
   );

   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl_cmd       (ctl_cmd),
      .req_command   (req_chan.command),
      .req_value     (req_chan.value),
      .req_position  (req_chan.position),
      .rsp_data      (rsp_chan.data),
      .rsp_occupancy (rsp_chan.occupancy),
      .rsp_error     (rsp_chan.error)
   );

   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(ctl_cmd.load))
      else $error("Result beat appeared without a load from the pending stage.");

   a_take_after_hold: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.take |=> ctl_status.busy)
      else $error("Accepted command did not move into the pending stage.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error == ERR_FULL |-> rsp_chan.occupancy == FULL_OCC)
      else $error("Full error reported with a count below the depth.");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error == ERR_EMPTY
         |-> rsp_chan.occupancy == '0 && rsp_chan.data == '0)
      else $error("Empty error reported with a non-zero count or data.");

endmodule
